// File: sv/deque_with_value_delete_defines.svh
`ifndef DEQUE_WITH_VALUE_DELETE_DEFINES_SVH
`define DEQUE_WITH_VALUE_DELETE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define DQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// next-cycle implication, disabled while in reset
`define DQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

// File: sv/dqvd_pkg.sv
package dqvd_pkg;

    // DEPTH must be a power of two: slot indexes wrap by truncation
    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    typedef logic [ADDR_W-1:0]      t_addr;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [VALUE_WIDTH-1:0] t_value;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DELETE     = 3'd4,
        OP_CHECK      = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RD_FRONT,
        S_RD_BACK,
        S_CAP_BACK,
        S_FIN
    } t_state;

endpackage

// File: sv/dqvd_ram.sv
module dqvd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/deque_with_value_delete.sv
// Sequence: push/pop go from accept through S_RD_FRONT, S_RD_BACK, S_CAP_BACK
// and S_FIN to the result; delete/check first scan in S_SCAN (check stops at
// the first match). One transaction at a time: next accept in the cycle after
// the result is loaded, which S_FIN defers while an earlier result is untaken;
// the scan compares one stored entry per cycle through one RAM read port.
// Reset (synchronous, active low): queue empty, head at slot 0, no result
// pending. Entry storage is not cleared.
`include "deque_with_value_delete_defines.svh"

module deque_with_value_delete (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [2:0]                 i_operation,
    input  logic [31:0]                i_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_status,
    output logic                       o_found,
    output logic [dqvd_pkg::CNT_W-1:0] o_entry_count,
    output logic [31:0]                o_front_value,
    output logic [31:0]                o_back_value
);

    import dqvd_pkg::*;

    t_state  r_state, n_state;
    t_op     r_op, n_op;
    t_value  r_value, n_value;
    t_addr   r_head, n_head;
    t_cnt    r_occ, n_occ;
    t_cnt    r_rd_idx, n_rd_idx;
    t_cnt    r_kept, n_kept;
    logic    r_cmp_vld, n_cmp_vld;
    logic    r_found, n_found;
    t_status r_status, n_status;
    t_value  r_front, n_front;
    t_value  r_back, n_back;

    logic    r_out_vld;
    t_status r_out_status;
    logic    r_out_found;
    t_cnt    r_out_count;
    t_value  r_out_front;
    t_value  r_out_back;

    logic    in_acc;
    logic    out_load;
    logic    full;
    logic    empty;
    logic    issue;
    logic    match;
    logic    scan_done;

    logic    ram_we;
    t_addr   ram_waddr;
    t_value  ram_wdata;
    t_addr   ram_raddr;
    t_value  ram_rdata;

    dqvd_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_ready   = (r_state == S_IDLE);
    assign in_acc    = i_valid && o_ready;
    assign full      = (r_occ == CNT_W'(DEPTH));
    assign empty     = (r_occ == '0);
    assign issue     = (r_rd_idx < r_occ);
    assign match     = (ram_rdata == r_value);
    assign scan_done = !issue || ((r_op == OP_CHECK) && r_cmp_vld && match);
    assign out_load  = (r_state == S_FIN) && (!r_out_vld || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if ((t_op'(i_operation) == OP_DELETE) ||
                        (t_op'(i_operation) == OP_CHECK)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_RD_FRONT;
                    end
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_RD_FRONT;
                end
            end
            S_RD_FRONT: n_state = S_RD_BACK;
            S_RD_BACK:  n_state = S_CAP_BACK;
            S_CAP_BACK: n_state = S_FIN;
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_op      = r_op;
        n_value   = r_value;
        n_head    = r_head;
        n_occ     = r_occ;
        n_rd_idx  = r_rd_idx;
        n_kept    = r_kept;
        n_cmp_vld = r_cmp_vld;
        n_found   = r_found;
        n_status  = r_status;
        n_front   = r_front;
        n_back    = r_back;
        ram_we    = 1'b0;
        ram_waddr = r_head;
        ram_wdata = r_value;
        ram_raddr = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op      = t_op'(i_operation);
                    n_value   = i_value[VALUE_WIDTH-1:0];
                    n_rd_idx  = '0;
                    n_kept    = '0;
                    n_cmp_vld = 1'b0;
                    n_found   = 1'b0;
                    n_status  = ST_DONE;
                    ram_wdata = i_value[VALUE_WIDTH-1:0];
                    unique case (t_op'(i_operation))
                        OP_PUSH_BACK: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_head + r_occ[ADDR_W-1:0];
                                n_occ     = r_occ + CNT_W'(1);
                            end
                        end
                        OP_PUSH_FRONT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_head - ADDR_W'(1);
                                n_head    = r_head - ADDR_W'(1);
                                n_occ     = r_occ + CNT_W'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            if (empty) begin
                                n_status = ST_MISS;
                            end else begin
                                n_head = r_head + ADDR_W'(1);
                                n_occ  = r_occ - CNT_W'(1);
                            end
                        end
                        OP_POP_BACK: begin
                            if (empty) begin
                                n_status = ST_MISS;
                            end else begin
                                n_occ = r_occ - CNT_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                // read slot rd_idx while comparing the entry read last cycle
                ram_raddr = r_head + r_rd_idx[ADDR_W-1:0];
                n_cmp_vld = issue;
                if (issue) begin
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                end
                if (r_cmp_vld) begin
                    if (match) begin
                        n_found = 1'b1;
                    end else if (r_op == OP_DELETE) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_head + r_kept[ADDR_W-1:0];
                        ram_wdata = ram_rdata;
                        n_kept    = r_kept + CNT_W'(1);
                    end
                end
                if (scan_done) begin
                    n_cmp_vld = 1'b0;
                    n_status  = n_found ? ST_DONE : ST_MISS;
                    if (r_op == OP_DELETE) begin
                        n_occ = n_kept;
                    end
                end
            end
            S_RD_FRONT: begin
                ram_raddr = r_head;
            end
            S_RD_BACK: begin
                ram_raddr = r_head + r_occ[ADDR_W-1:0] - ADDR_W'(1);
                n_front   = empty ? '0 : ram_rdata;
            end
            S_CAP_BACK: begin
                n_back = empty ? '0 : ram_rdata;
            end
            S_FIN: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_occ     <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_occ     <= n_occ;
            r_cmp_vld <= n_cmp_vld;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_value  <= n_value;
        r_rd_idx <= n_rd_idx;
        r_kept   <= n_kept;
        r_found  <= n_found;
        r_status <= n_status;
        r_front  <= n_front;
        r_back   <= n_back;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_found  <= r_found;
            r_out_count  <= r_occ;
            r_out_front  <= r_front;
            r_out_back   <= r_back;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_status      = r_out_status;
    assign o_found       = r_out_found;
    assign o_entry_count = r_out_count;
    assign o_front_value = 32'(r_out_front);
    assign o_back_value  = 32'(r_out_back);

    `DQ_ASSERT_NOW(a_occ_bound, 1'b1, r_occ <= CNT_W'(DEPTH))
    `DQ_ASSERT_NEXT(a_busy_after_accept, in_acc, r_state != S_IDLE)
    `DQ_ASSERT_NOW(a_compact_behind_read, (r_state == S_SCAN) && ram_we, r_kept < r_rd_idx)
    `DQ_ASSERT_NOW(a_empty_reads_zero, r_out_vld && (r_out_count == '0),
                   (r_out_front == '0) && (r_out_back == '0))

endmodule
